>>> rtl/core/sus_pkg.sv
`timescale 1ns / 1ps
package sus_pkg;

	localparam int unsigned DEF_CAPACITY = 64;
	localparam int unsigned MAX_CAPACITY = 64;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned CNT_W        = 7;
	localparam int unsigned REQ_W        = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_CONTAINS = 2'd1,
		REQ_SIZE     = 2'd2,
		REQ_PRINT    = 2'd3
	} req_t;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic load;    // insert: cells at or above the slot move up by one
		logic rotate;  // print: each cell takes its right-hand neighbour, the tail cell takes cell 0
	} cell_ctrl_t;

endpackage

>>> rtl/core/sus_cell.sv
`timescale 1ns / 1ps
module sus_cell (
	input  logic                                clk,
	input  sus_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [sus_pkg::KEY_W-1:0]    key,
	input  logic                                occupied,
	input  logic                                tail,
	input  logic                                left_less,
	input  logic signed [sus_pkg::KEY_W-1:0]    left_value,
	input  logic signed [sus_pkg::KEY_W-1:0]    right_value,
	input  logic signed [sus_pkg::KEY_W-1:0]    wrap_value,
	output logic signed [sus_pkg::KEY_W-1:0]    value,
	output logic                                less,
	output logic                                eq
);
	import sus_pkg::*;

	logic signed [KEY_W-1:0] value_q;

	assign value = value_q;
	assign less  = occupied && (value_q < key);
	assign eq    = occupied && (value_q == key);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			// the first cell not below the key takes it, those above take the left value
			if (!less) begin
				value_q <= left_less ? key : left_value;
			end
		end else if (ctrl.rotate) begin
			value_q <= tail ? wrap_value : right_value;
		end
	end

endmodule

>>> rtl/core/sorted_unique_set.sv
`timescale 1ns / 1ps
// channel  dir  tdata                                    tuser        tlast
// s_*      in   [31:0] key_value                         [1:0] req    -
// m_*      out  [31:0] element_value, [32] found,        [0] empty    last_item
//               [39:33] set_count, [40] set_full
//
// Insert, contains and size are taken one item per cycle while the output is not stalled.
// A print of n values holds the input until its last value is loaded: the cell row rotates
// by one place per item and cell 0 feeds the single output register.
// Reset clears the count; cell contents are left as they are.
// A stalled output holds the result and stops both the input and the rotation.
module sorted_unique_set #(
	parameter int unsigned SET_CAPACITY = sus_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key_value
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] element_value, [32] found, [39:33] set_count,
	                               // [40] set_full, [47:41] zero
	output logic [0:0]  m_tuser,   // [0] empty_mark
	output logic        m_tlast
);
	import sus_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        pr_idx_q;
	logic                    busy_q;

	logic                    out_valid_q;
	logic signed [KEY_W-1:0] out_elem_q;
	logic                    out_found_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic                    out_full_q;
	logic                    out_empty_q;
	logic                    out_last_q;

	logic signed [KEY_W-1:0] res_elem;
	logic                    res_found;
	logic [CNT_W-1:0]        res_cnt;
	logic                    res_full;
	logic                    res_empty;
	logic                    res_last;

	logic signed [KEY_W-1:0] key;
	req_t                    req;
	logic signed [KEY_W-1:0] cell_val [SET_CAPACITY];
	logic [SET_CAPACITY-1:0] less_v;
	logic [SET_CAPACITY-1:0] eq_v;
	logic                    hit;
	logic                    out_free;
	logic                    in_acc;
	logic                    print_run;
	logic                    do_ins;
	logic                    pr_step;
	logic                    pr_last;
	logic                    load_out;
	cell_ctrl_t              ctrl;

	assign key       = s_tdata[KEY_W-1:0];
	assign req       = req_t'(s_tuser);
	assign hit       = |eq_v;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = !busy_q && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign print_run = (req == REQ_PRINT) && (count_q != '0);
	assign do_ins    = in_acc && (req == REQ_INSERT) && !hit && (count_q < CAP_CNT);
	assign pr_step   = busy_q && out_free;
	assign pr_last   = (pr_idx_q == count_q - CNT_W'(1));
	assign load_out  = (in_acc && !print_run) || pr_step;

	assign ctrl.load   = do_ins;
	assign ctrl.rotate = pr_step;

	for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
		logic                    left_less;
		logic signed [KEY_W-1:0] left_value;
		logic signed [KEY_W-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_less  = 1'b1;
			assign left_value = key;
		end else begin : g_mid
			assign left_less  = less_v[i-1];
			assign left_value = cell_val[i-1];
		end
		if (i == SET_CAPACITY - 1) begin : g_end
			assign right_value = cell_val[0];
		end else begin : g_inner
			assign right_value = cell_val[i+1];
		end

		sus_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.key         (key),
			.occupied    (CNT_W'(i) < count_q),
			.tail        (count_q == CNT_W'(i + 1)),
			.left_less   (left_less),
			.left_value  (left_value),
			.right_value (right_value),
			.wrap_value  (cell_val[0]),
			.value       (cell_val[i]),
			.less        (less_v[i]),
			.eq          (eq_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			pr_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (in_acc && print_run) begin
				busy_q   <= 1'b1;
				pr_idx_q <= '0;
			end else if (pr_step) begin
				pr_idx_q <= pr_idx_q + CNT_W'(1);
				if (pr_last) begin
					busy_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_valid_q <= load_out;
			end
		end
	end

	always_comb begin
		res_elem  = '0;
		res_found = 1'b0;
		res_cnt   = count_q;
		res_full  = 1'b0;
		res_empty = 1'b0;
		res_last  = 1'b1;
		if (pr_step) begin
			res_elem = cell_val[0];
			res_last = pr_last;
		end else begin
			unique case (req)
				REQ_INSERT: begin
					res_cnt  = count_q + CNT_W'(do_ins);
					res_full = !hit && (count_q >= CAP_CNT);
				end
				REQ_CONTAINS: res_found = hit;
				REQ_SIZE:     res_cnt   = count_q;
				REQ_PRINT:    res_empty = 1'b1;
				default:      res_cnt   = count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load_out) begin
			out_elem_q  <= res_elem;
			out_found_q <= res_found;
			out_cnt_q   <= res_cnt;
			out_full_q  <= res_full;
			out_empty_q <= res_empty;
			out_last_q  <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_full_q, out_cnt_q, out_found_q, out_elem_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready) else $error("input taken during print");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT) else $error("count beyond capacity");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("count moved by more than one");

	a_print_count_still: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(count_q)) else $error("count changed during print");

	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> (out_last_q && out_elem_q == '0 && out_cnt_q == '0))
		else $error("malformed empty print item");

endmodule

>>> tb/sorted_unique_set_tb.sv
`timescale 1ns / 1ps
module sorted_unique_set_tb;
	import sus_pkg::*;

	localparam int unsigned CAPACITY   = DEF_CAPACITY;
	localparam int unsigned N_RANDOM   = 200;
	localparam int unsigned TAIL_WAIT  = 20;
	localparam realtime     RUN_LIMIT  = 10_000_000.0;

	typedef struct packed {
		logic [31:0] element;
		logic        found;
		logic [6:0]  count;
		logic        full;
		logic        empty;
		logic        last;
	} set_result_t;

	class set_scoreboard;
		int unsigned        capacity;
		logic signed [31:0] members[$];
		set_result_t        pending_q[$];
		int unsigned        errors;

		function new(int unsigned cap);
			capacity = cap;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// Mirrors the set: members is kept sorted in signed order.
		function void note_request(req_t req, logic signed [31:0] key);
			set_result_t r;
			int unsigned pos;
			bit present;
			r = '0;
			r.last = 1'b1;
			if (req == REQ_PRINT) begin
				if (members.size() == 0) begin
					r.empty = 1'b1;
					pending_q.push_back(r);
				end else begin
					foreach (members[i]) begin
						r.element = members[i];
						r.count = 7'(members.size());
						r.last = (i == members.size() - 1);
						pending_q.push_back(r);
					end
				end
				return;
			end
			pos = 0;
			while (pos < members.size() && members[pos] < key)
				pos++;
			present = (pos < members.size()) && (members[pos] == key);
			case (req)
				REQ_INSERT: begin
					if (!present) begin
						if (members.size() >= capacity)
							r.full = 1'b1;
						else
							members.insert(pos, key);
					end
				end
				REQ_CONTAINS: r.found = present;
				default: ;
			endcase
			r.count = 7'(members.size());
			pending_q.push_back(r);
		endfunction

		task check_result(set_result_t got);
			set_result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected item elem=%0d last=%b", $signed(got.element),
					got.last));
			end else begin
				want = pending_q.pop_front();
				if (got !== want)
					report($sformatf({"elem %0d/%0d found %b/%b cnt %0d/%0d full %b/%b ",
						"empty %b/%b last %b/%b (got/exp)"},
						$signed(got.element), $signed(want.element), got.found, want.found,
						got.count, want.count, got.full, want.full, got.empty, want.empty,
						got.last, want.last));
			end
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	logic [31:0]   used_keys[$];
	set_scoreboard sb = new(CAPACITY);

	sorted_unique_set #(.SET_CAPACITY(CAPACITY)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Everything changes on the rising edge, so the falling edge sees what the next
	// rising edge will capture.
	always @(negedge clk) begin
		set_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.element = m_tdata[31:0];
			got.found   = m_tdata[32];
			got.count   = m_tdata[39:33];
			got.full    = m_tdata[40];
			got.empty   = m_tuser[0];
			got.last    = m_tlast;
			sb.check_result(got);
		end
	end

	// Called at a rising edge; returns at the rising edge that takes the item.
	task send_item(req_t req, logic [31:0] key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= req;
		do
			@(negedge clk);
		while (!s_tready);
		sb.note_request(req, key);
		if (req == REQ_INSERT)
			used_keys.push_back(key);
		@(posedge clk);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_q.size() != 0);
	endtask

	function automatic logic [31:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 25 && used_keys.size() > 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		if (sel < 35) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'hffff_ffff;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom();
	endfunction

	function automatic req_t pick_req();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return REQ_INSERT;
		if (sel < 75)
			return REQ_CONTAINS;
		if (sel < 85)
			return REQ_SIZE;
		return REQ_PRINT;
	endfunction

	initial begin
		int unsigned phase;
		int unsigned prev_phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 35;
		recv_idle_pct = 47;

		// empty set first, then extremes, duplicates and lookups
		send_item(REQ_PRINT,    32'h1234_5678);
		send_item(REQ_SIZE,     32'hffff_ffff);
		send_item(REQ_CONTAINS, 32'h0000_0000);
		send_item(REQ_INSERT,   32'h7fff_ffff);
		send_item(REQ_INSERT,   32'h8000_0000);
		send_item(REQ_INSERT,   32'h0000_0000);
		send_item(REQ_INSERT,   32'hffff_ffff);
		send_item(REQ_INSERT,   32'h0000_0001);
		send_item(REQ_INSERT,   32'h0000_0000);
		send_item(REQ_INSERT,   32'h8000_0000);
		send_item(REQ_CONTAINS, 32'h8000_0000);
		send_item(REQ_CONTAINS, 32'h7fff_ffff);
		send_item(REQ_CONTAINS, 32'h0000_0005);
		send_item(REQ_CONTAINS, 32'h7fff_fffe);
		send_item(REQ_SIZE,     32'h0000_0000);
		send_item(REQ_PRINT,    32'h0000_0000);
		send_item(REQ_INSERT,   32'haaaa_aaaa);
		send_item(REQ_INSERT,   32'h5555_5555);
		send_item(REQ_PRINT,    32'hffff_ffff);
		wait_drained();

		prev_phase = 0;
		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			phase = i * 3 / N_RANDOM;
			if (phase != prev_phase) begin
				// hold off until the block has emptied out, then change the idling mix
				wait_drained();
				send_idle_pct = (phase == 1) ? 47 : 0;
				recv_idle_pct = (phase == 1) ? 35 : 0;
				prev_phase = phase;
			end
			send_item(pick_req(), pick_key());
		end

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sus_pkg.sv
rtl/core/sus_cell.sv
rtl/core/sorted_unique_set.sv
tb/sorted_unique_set_tb.sv
